// File: hdl/sdfrm_pkg.sv
// Shared types, scene constants and helper functions for the sphere-tracing ray march core.
// Used by sdf_sphere_trace_ray_march_core, sdfrm_isqrt and sdfrm_div; no dependencies.
package sdfrm_pkg;

    localparam int C_W  = 31;   // march and probe point coordinate, signed
    localparam int D_W  = 35;   // signed distance
    localparam int SQ_W = 62;   // sum of three squares
    localparam int RT_W = 31;   // square root of a sum of squares
    localparam int G_W  = 30;   // probe difference, signed
    localparam int T_W  = 34;   // distance travelled, unsigned
    localparam int M_W  = 32;   // shared multiplier operand width
    localparam int P_W  = 64;   // shared multiplier product width

    localparam int NSPH    = 11;
    localparam int DEC_ONE = 100000;
    localparam longint FLOOR_DEC = 64'sd10000000;
    localparam longint POS_LIM   = 64'sd536870912;  // 2^29
    localparam longint DIFF_LIM  = 64'sd268435456;  // 2^28

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_FLOOR   = 3'd1;
    localparam logic [2:0] KIND_PURPLE  = 3'd2;
    localparam logic [2:0] KIND_GREEN   = 3'd3;
    localparam logic [2:0] KIND_CYAN    = 3'd4;
    localparam logic [2:0] KIND_ORANGE  = 3'd5;
    localparam logic [2:0] KIND_MAGENTA = 3'd6;
    localparam logic [2:0] KIND_BLUE    = 3'd7;

    localparam logic [1:0] CFG_HIT_EPSILON  = 2'd0;
    localparam logic [1:0] CFG_MAX_DISTANCE = 2'd1;
    localparam logic [1:0] CFG_MAX_STEPS    = 2'd2;
    localparam logic [1:0] CFG_NORMAL_STEP  = 2'd3;

    typedef logic signed [C_W-1:0] coord_tab_t [NSPH];

    // Sphere centers and radii in units of 1e-5, listed in material group order:
    // purple, magenta, green, cyan, orange, blue.
    localparam int SPH_DEC [NSPH][4] = '{
        '{      0, 50000,       0, 50000 },
        '{  97972, 37500,  -77931, 37500 },
        '{ -80000, 25000,  -80000, 25000 },
        '{ 152095, 99900,  154815, 99900 },
        '{  40156, 15000, -101220, 15000 },
        '{ -63181, 15000,  -36635, 15000 },
        '{ -21409, 75000,  204146, 75000 },
        '{ 122597, 40000,   12727, 40000 },
        '{-131409, 75000,   34146, 75000 },
        '{ -35713, 25000,   91613, 25000 },
        '{  30007, 15000, -159347, 15000 }
    };

    localparam logic [2:0] SPH_KIND [NSPH] = '{
        KIND_PURPLE, KIND_PURPLE, KIND_PURPLE, KIND_MAGENTA, KIND_MAGENTA,
        KIND_GREEN, KIND_GREEN, KIND_CYAN, KIND_ORANGE, KIND_ORANGE, KIND_BLUE
    };

    // Decimal constant to fixed point, rounded to nearest with ties away from zero.
    function automatic longint to_fix(longint v, int frac);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = ((m << frac) + DEC_ONE / 2) / DEC_ONE;
        return (v < 0) ? -r : r;
    endfunction

    function automatic coord_tab_t sph_tab(int comp, int frac);
        coord_tab_t t;
        for (int i = 0; i < NSPH; i++) begin
            t[i] = C_W'(to_fix(longint'(SPH_DEC[i][comp]), frac));
        end
        return t;
    endfunction

    function automatic logic signed [63:0] sat64(logic signed [63:0] v,
                                                 logic signed [63:0] lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

// File: hdl/sdfrm_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on sdfrm_pkg for the radicand and root widths.
module sdfrm_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sdfrm_pkg::SQ_W-1:0]  radicand,
    output logic                        done,
    output logic [sdfrm_pkg::RT_W-1:0]  root
);
    import sdfrm_pkg::*;

    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] bit_reg;
    logic            run_reg;
    logic            done_reg;
    logic [SQ_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg   <= radicand;
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (n_reg >= trial) begin
                    n_reg   <= n_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[RT_W-1:0];

endmodule

// File: hdl/sdfrm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sdfrm_pkg for the divisor width.
module sdfrm_div #(
    parameter int NUM_W = 46
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    input  logic [sdfrm_pkg::RT_W-1:0]  den,
    output logic                        done,
    output logic [NUM_W-1:0]            quo
);
    import sdfrm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [RT_W-1:0]  rem_reg;
    logic [RT_W-1:0]  den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [RT_W:0]    shifted;
    logic             fits;

    assign shifted = {rem_reg, q_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg   <= num;
                rem_reg <= '0;
                den_reg <= den;
                cnt_reg <= CNT_W'(NUM_W);
                run_reg <= 1'b1;
            end else if (run_reg) begin
                rem_reg <= fits ? RT_W'(shifted - {1'b0, den_reg}) : shifted[RT_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// File: hdl/sdf_sphere_trace_ray_march_core.sv
// Top level of the sphere-tracing ray march core.
// Depends on sdfrm_pkg, sdfrm_isqrt and sdfrm_div.

// The core takes one ray request at a time (origin and unit direction, fixed
// point with FRAC_BITS fraction bits) and returns one result request with the
// material kind, the distance travelled and a unit surface normal. s_ready is
// high only while the sequencer is idle; a finished result sits in the output
// register while the next ray is taken. Every signed-distance query walks the
// eleven spheres one at a time through a single registered multiplier (three
// squares each) and a shared iterative square root that resolves two radicand
// bits per cycle, then scans the six floor-slab planes; the square roots dominate
// the cost of a query. A ray takes one query per march step, plus, on a hit,
// three normal probes, the normal length root and three divisions. Configuration
// writes take effect at once and should only be issued while no ray is in flight.
module sdf_sphere_trace_ray_march_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [22:0]         cfg_wdata,
    // ray requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [23:0]  s_origin_x,
    input  logic signed [23:0]  s_origin_y,
    input  logic signed [23:0]  s_origin_z,
    input  logic signed [17:0]  s_dir_x,
    input  logic signed [17:0]  s_dir_y,
    input  logic signed [17:0]  s_dir_z,
    // result requests
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_hit_kind,
    output logic [22:0]         m_traveled,
    output logic signed [17:0]  m_normal_x,
    output logic signed [17:0]  m_normal_y,
    output logic signed [17:0]  m_normal_z
);
    import sdfrm_pkg::*;

    localparam int NUM_W = G_W - 1 + FRAC_BITS + 1;

    // Scene constants scaled to the chosen fraction width.
    localparam coord_tab_t SPH_X = sph_tab(0, FRAC_BITS);
    localparam coord_tab_t SPH_Y = sph_tab(1, FRAC_BITS);
    localparam coord_tab_t SPH_Z = sph_tab(2, FRAC_BITS);
    localparam coord_tab_t SPH_R = sph_tab(3, FRAC_BITS);
    localparam logic signed [D_W-1:0] FLOOR_HI = D_W'(to_fix(FLOOR_DEC, FRAC_BITS));

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_PMUL, S_PADD, S_QSTART, S_SQMUL, S_SQACC, S_ROOT,
        S_FLOOR, S_QDONE, S_PROBE, S_LSQMUL, S_LSQACC, S_LROOT, S_DIVGO,
        S_DIVWAIT, S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [16:0] hit_eps_reg;
    logic [22:0] max_dist_reg;
    logic [7:0]  max_steps_reg;
    logic [16:0] normal_step_reg;

    // ray and march state
    logic signed [23:0]     o_reg   [3];
    logic signed [17:0]     dr_reg  [3];
    logic signed [C_W-1:0]  p_reg   [3];
    logic signed [C_W-1:0]  q_reg   [3];
    logic signed [G_W-1:0]  g_reg   [3];
    logic signed [17:0]     nrm_reg [3];
    logic [T_W-1:0]         total_reg;
    logic [8:0]             steps_reg;
    logic [1:0]             axis_reg;
    logic [1:0]             paxis_reg;
    logic                   probe_reg;
    logic [3:0]             sph_reg;
    logic [2:0]             fl_reg;
    logic [SQ_W-1:0]        acc_reg;
    logic signed [D_W-1:0]  best_reg;
    logic [2:0]             kind_reg;
    logic signed [D_W-1:0]  fmin_reg;
    logic signed [D_W-1:0]  dc_reg;
    logic [2:0]             res_kind_reg;
    logic [22:0]            res_trav_reg;
    logic [RT_W-1:0]        len_reg;
    logic signed [P_W-1:0]  prod_reg;

    // output register
    logic                   m_valid_reg;
    logic [2:0]             out_kind_reg;
    logic [22:0]            out_trav_reg;
    logic signed [17:0]     out_nrm_reg [3];

    // shared multiplier operands
    logic signed [M_W-1:0]  mul_a;
    logic signed [M_W-1:0]  mul_b;
    logic signed [C_W-1:0]  sph_coord;
    logic signed [M_W-1:0]  sph_diff;

    logic signed [63:0]     pos_sum;
    logic signed [63:0]     probe_sum;
    logic signed [D_W-1:0]  sph_dist;
    logic signed [D_W-1:0]  floor_c;
    logic signed [D_W-1:0]  neg_fmin;
    logic signed [D_W-1:0]  qbest;
    logic [2:0]             qkind;
    logic signed [63:0]     gdiff;
    logic [8:0]             steps_inc;
    logic [SQ_W-1:0]        acc_sum;

    logic                   root_start;
    logic                   root_done;
    logic [RT_W-1:0]        root;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_num;
    logic [NUM_W-1:0]       quo;
    logic [G_W-1:0]         g_mag;
    logic [17:0]            quo_lo;

    always_comb begin
        case (axis_reg)
            2'd0:    sph_coord = SPH_X[sph_reg];
            2'd1:    sph_coord = SPH_Y[sph_reg];
            default: sph_coord = SPH_Z[sph_reg];
        endcase
    end

    assign sph_diff = M_W'(sph_coord) - M_W'(q_reg[axis_reg]);

    always_comb begin
        unique case (state_reg)
            S_PMUL: begin
                mul_a = M_W'(dr_reg[axis_reg]);
                mul_b = M_W'($signed({1'b0, total_reg[23:0]}));
            end
            S_LSQMUL: begin
                mul_a = M_W'(g_reg[axis_reg]);
                mul_b = M_W'(g_reg[axis_reg]);
            end
            default: begin
                mul_a = sph_diff;
                mul_b = sph_diff;
            end
        endcase
    end

    // Point on the ray, and the probe point one normal_step further along an axis.
    assign pos_sum   = sat64(64'(o_reg[axis_reg]) + (prod_reg >>> FRAC_BITS), POS_LIM);
    assign probe_sum = sat64(64'(p_reg[paxis_reg]) + 64'($signed({1'b0, normal_step_reg})),
                             POS_LIM);

    assign sph_dist = D_W'($signed({1'b0, root})) - D_W'(SPH_R[sph_reg]);

    // The six slab planes of the floor box.
    always_comb begin
        case (fl_reg)
            3'd0:    floor_c = D_W'(q_reg[0]) + FLOOR_HI;
            3'd1:    floor_c = D_W'(q_reg[1]) + FLOOR_HI;
            3'd2:    floor_c = D_W'(q_reg[2]) + FLOOR_HI;
            3'd3:    floor_c = FLOOR_HI - D_W'(q_reg[0]);
            3'd4:    floor_c = -D_W'(q_reg[1]);
            default: floor_c = FLOOR_HI - D_W'(q_reg[2]);
        endcase
    end

    // The floor wins only when strictly closer than every sphere group.
    assign neg_fmin = -fmin_reg;
    assign qbest    = (neg_fmin < best_reg) ? neg_fmin : best_reg;
    assign qkind    = (neg_fmin < best_reg) ? KIND_FLOOR : kind_reg;
    assign gdiff    = sat64(64'(qbest) - 64'(dc_reg), DIFF_LIM);
    assign steps_inc = steps_reg + 9'd1;
    assign acc_sum  = acc_reg + prod_reg[SQ_W-1:0];

    assign root_start = ((state_reg == S_SQACC) || (state_reg == S_LSQACC))
                        && (axis_reg == 2'd2);
    assign div_start  = (state_reg == S_DIVGO);

    // Rounded quotient: (|g| << FRAC_BITS + len / 2) / len.
    assign g_mag   = g_reg[axis_reg][G_W-1] ? G_W'(-g_reg[axis_reg]) : G_W'(g_reg[axis_reg]);
    assign div_num = (NUM_W'(g_mag) << FRAC_BITS) + NUM_W'(len_reg >> 1);
    assign quo_lo  = quo[17:0];

    sdfrm_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_sum),
        .done     (root_done),
        .root     (root)
    );

    sdfrm_div #(.NUM_W(NUM_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (len_reg),
        .done    (div_done),
        .quo     (quo)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_eps_reg     <= 17'd655;
            max_dist_reg    <= 23'd6553600;
            max_steps_reg   <= 8'd100;
            normal_step_reg <= 17'd655;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HIT_EPSILON:  hit_eps_reg     <= cfg_wdata[16:0];
                CFG_MAX_DISTANCE: max_dist_reg    <= cfg_wdata;
                CFG_MAX_STEPS:    max_steps_reg   <= cfg_wdata[7:0];
                CFG_NORMAL_STEP:  normal_step_reg <= cfg_wdata[16:0];
            endcase
        end
    end

    // The shared multiplier is registered on every cycle; the sequencer reads
    // the product one state after it presents the operands.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded instead.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        o_reg[0]  <= s_origin_x;
                        o_reg[1]  <= s_origin_y;
                        o_reg[2]  <= s_origin_z;
                        dr_reg[0] <= s_dir_x;
                        dr_reg[1] <= s_dir_y;
                        dr_reg[2] <= s_dir_z;
                        total_reg <= '0;
                        steps_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (total_reg >= T_W'(max_dist_reg)) begin
                        // Ran past the far limit: a miss with nothing travelled.
                        res_kind_reg <= KIND_NONE;
                        res_trav_reg <= '0;
                        nrm_reg[0]   <= '0;
                        nrm_reg[1]   <= '0;
                        nrm_reg[2]   <= '0;
                        state_reg    <= S_DONE;
                    end else begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    state_reg <= S_PADD;
                end
                S_PADD: begin
                    p_reg[axis_reg] <= C_W'(pos_sum);
                    q_reg[axis_reg] <= C_W'(pos_sum);
                    if (axis_reg == 2'd2) begin
                        probe_reg <= 1'b0;
                        state_reg <= S_QSTART;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_PMUL;
                    end
                end
                S_QSTART: begin
                    sph_reg   <= '0;
                    axis_reg  <= 2'd0;
                    acc_reg   <= '0;
                    state_reg <= S_SQMUL;
                end
                S_SQMUL: begin
                    state_reg <= S_SQACC;
                end
                S_SQACC: begin
                    acc_reg <= acc_sum;
                    if (axis_reg == 2'd2) begin
                        state_reg <= S_ROOT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_SQMUL;
                    end
                end
                S_ROOT: begin
                    if (root_done) begin
                        // Spheres are visited in material group order, so a
                        // strict compare keeps ties with the earlier group.
                        if ((sph_reg == 4'd0) || (sph_dist < best_reg)) begin
                            best_reg <= sph_dist;
                            kind_reg <= SPH_KIND[sph_reg];
                        end
                        if (sph_reg == 4'(NSPH - 1)) begin
                            fl_reg    <= '0;
                            state_reg <= S_FLOOR;
                        end else begin
                            sph_reg   <= sph_reg + 4'd1;
                            axis_reg  <= 2'd0;
                            acc_reg   <= '0;
                            state_reg <= S_SQMUL;
                        end
                    end
                end
                S_FLOOR: begin
                    if ((fl_reg == 3'd0) || (floor_c < fmin_reg)) begin
                        fmin_reg <= floor_c;
                    end
                    if (fl_reg == 3'd5) begin
                        state_reg <= S_QDONE;
                    end else begin
                        fl_reg <= fl_reg + 3'd1;
                    end
                end
                S_QDONE: begin
                    if (probe_reg) begin
                        g_reg[paxis_reg] <= G_W'(gdiff);
                        if (paxis_reg == 2'd2) begin
                            axis_reg  <= 2'd0;
                            acc_reg   <= '0;
                            state_reg <= S_LSQMUL;
                        end else begin
                            paxis_reg <= paxis_reg + 2'd1;
                            state_reg <= S_PROBE;
                        end
                    end else if (qbest < $signed({{(D_W-17){1'b0}}, hit_eps_reg})) begin
                        res_kind_reg <= qkind;
                        res_trav_reg <= total_reg[22:0];
                        dc_reg       <= qbest;
                        paxis_reg    <= 2'd0;
                        state_reg    <= S_PROBE;
                    end else if (steps_inc >= {1'b0, max_steps_reg}) begin
                        // Step budget used up: a miss that keeps the distance.
                        res_kind_reg <= KIND_NONE;
                        res_trav_reg <= total_reg[22:0];
                        nrm_reg[0]   <= '0;
                        nrm_reg[1]   <= '0;
                        nrm_reg[2]   <= '0;
                        state_reg    <= S_DONE;
                    end else begin
                        steps_reg <= steps_inc;
                        total_reg <= total_reg + T_W'(qbest);
                        state_reg <= S_CHECK;
                    end
                end
                S_PROBE: begin
                    q_reg[0]  <= (paxis_reg == 2'd0) ? C_W'(probe_sum) : p_reg[0];
                    q_reg[1]  <= (paxis_reg == 2'd1) ? C_W'(probe_sum) : p_reg[1];
                    q_reg[2]  <= (paxis_reg == 2'd2) ? C_W'(probe_sum) : p_reg[2];
                    probe_reg <= 1'b1;
                    state_reg <= S_QSTART;
                end
                S_LSQMUL: begin
                    state_reg <= S_LSQACC;
                end
                S_LSQACC: begin
                    acc_reg <= acc_sum;
                    if (axis_reg == 2'd2) begin
                        state_reg <= S_LROOT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_LSQMUL;
                    end
                end
                S_LROOT: begin
                    if (root_done) begin
                        len_reg <= root;
                        if (root == '0) begin
                            // Flat gradient: report a zero normal.
                            nrm_reg[0] <= '0;
                            nrm_reg[1] <= '0;
                            nrm_reg[2] <= '0;
                            state_reg  <= S_DONE;
                        end else begin
                            axis_reg  <= 2'd0;
                            state_reg <= S_DIVGO;
                        end
                    end
                end
                S_DIVGO: begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_done) begin
                        nrm_reg[axis_reg] <= g_reg[axis_reg][G_W-1] ? -$signed(quo_lo)
                                                                    : $signed(quo_lo);
                        if (axis_reg == 2'd2) begin
                            state_reg <= S_DONE;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DIVGO;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        out_kind_reg   <= res_kind_reg;
                        out_trav_reg   <= res_trav_reg;
                        out_nrm_reg[0] <= nrm_reg[0];
                        out_nrm_reg[1] <= nrm_reg[1];
                        out_nrm_reg[2] <= nrm_reg[2];
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_hit_kind = out_kind_reg;
    assign m_traveled = out_trav_reg;
    assign m_normal_x = out_nrm_reg[0];
    assign m_normal_y = out_nrm_reg[1];
    assign m_normal_z = out_nrm_reg[2];

endmodule
